// ===== sv/wfm_pkg.sv =====
package wfm_pkg;

    // Cosine table geometry: one quarter wave of COS_DEPTH steps plus the end point.
    localparam int COS_DEPTH     = 1024;
    localparam int COS_IDX_W     = 11;
    localparam int COS_VAL_W     = 17;
    localparam int PHASE_W       = 12;

    // Quotient bits after the integer bit for the two phase divisions.
    localparam int DIV_STEPS_COS = 12;
    localparam int DIV_STEPS_LIN = 16;

    localparam int SAMPLE_W      = 16;
    localparam int WEIGHT_W      = 20;
    localparam int OUT_W         = 19;
    localparam int ACC_W         = 38;
    localparam int LEN_W         = 17;
    localparam int POS_W         = 16;
    localparam int MAX_FRAME     = 65536;

    localparam int W_MAX         = 524287;
    localparam int W_MIN         = -524288;
    localparam int OUT_MAX       = 262143;
    localparam int OUT_MIN       = -262144;
    localparam int ONE_Q16       = 65536;

    typedef enum logic [2:0] {
        MODE_HANN     = 3'd0,
        MODE_HAMMING  = 3'd1,
        MODE_BLACKMAN = 3'd2,
        MODE_BARTLETT = 3'd3,
        MODE_BHARRIS  = 3'd4,
        MODE_FLATTOP  = 3'd5
    } mode_t;

    typedef logic [COS_VAL_W-1:0] cos_rom_t [0:COS_DEPTH];

    typedef struct packed {
        logic accept;
        logic div_load;
        logic div_step;
        logic harm_init;
        logic harm_acc;
        logic weight;
        logic prod;
        logic out_load;
    } dp_cmd_t;

    typedef struct packed {
        logic rect;
        logic bartlett;
        logic last_harm;
    } dp_status_t;

    // Quarter-wave cosine in Q16, built at elaboration with a Q30 Taylor series.
    function automatic cos_rom_t build_cos_rom();
        cos_rom_t          rom;
        longint unsigned   x;
        longint unsigned   x2;
        longint unsigned   term;
        longint            sum;
        longint            e;
        for (int j = 0; j <= COS_DEPTH; j++)
        begin
            x    = (64'd1686629713 * 64'(j) + 64'(COS_DEPTH / 2)) / 64'(COS_DEPTH);
            x2   = (x * x) >> 30;
            term = 64'd1 << 30;
            sum  = longint'(term);
            for (int n = 1; n <= 12; n++)
            begin
                term = ((term * x2) >> 30) / 64'((2 * n - 1) * (2 * n));
                if (n % 2 == 1)
                    sum = sum - longint'(term);
                else
                    sum = sum + longint'(term);
            end
            if (sum < 0)
                sum = 0;
            e = (sum + 8192) / 16384;
            if (e > 65536)
                e = 65536;
            rom[j] = COS_VAL_W'(e);
        end
        return rom;
    endfunction

    // Constant term of each cosine-sum window, Q16.
    function automatic logic [16:0] base_coef(mode_t m);
        logic [16:0] c;
        case (m)
            MODE_HANN:     c = 17'd32768;
            MODE_HAMMING:  c = 17'd35389;
            MODE_BLACKMAN: c = 17'd27525;
            MODE_BHARRIS:  c = 17'd23511;
            default:       c = 17'd65536;
        endcase
        return c;
    endfunction

    // Signed Q16 coefficient of cos(2*pi*k*p).
    function automatic logic signed [17:0] harm_coef(mode_t m, logic [2:0] k);
        logic signed [17:0] c;
        c = '0;
        case (m)
            MODE_HANN:
            begin
                if (k == 3'd1) c = -18'sd32768;
            end
            MODE_HAMMING:
            begin
                if (k == 3'd1) c = -18'sd30147;
            end
            MODE_BLACKMAN:
            begin
                if (k == 3'd1) c = -18'sd32768;
                if (k == 3'd2) c = 18'sd5243;
            end
            MODE_BHARRIS:
            begin
                if (k == 3'd1) c = -18'sd32001;
                if (k == 3'd2) c = 18'sd9259;
                if (k == 3'd3) c = -18'sd765;
            end
            default:
            begin
                if (k == 3'd1) c = -18'sd126484;
                if (k == 3'd2) c = 18'sd84541;
                if (k == 3'd3) c = -18'sd25428;
                if (k == 3'd4) c = 18'sd2110;
            end
        endcase
        return c;
    endfunction

    function automatic logic [2:0] num_harm(mode_t m);
        logic [2:0] n;
        case (m)
            MODE_BLACKMAN: n = 3'd2;
            MODE_BHARRIS:  n = 3'd3;
            MODE_FLATTOP:  n = 3'd4;
            default:       n = 3'd1;
        endcase
        return n;
    endfunction

endpackage

// ===== sv/wfm_dp.sv =====
module wfm_dp
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  wfm_pkg::dp_cmd_t                     cmd,
    output wfm_pkg::dp_status_t                  status,
    input  logic [2:0]                           window_mode,
    input  logic [wfm_pkg::LEN_W-1:0]            frame_length,
    input  logic [wfm_pkg::SAMPLE_W-1:0]         sample,
    output logic [wfm_pkg::OUT_W-1:0]            windowed,
    output logic                                 frame_end
);

    localparam wfm_pkg::cos_rom_t COS_ROM = wfm_pkg::build_cos_rom();

    logic [wfm_pkg::POS_W-1:0]           position_reg;
    logic [wfm_pkg::POS_W-1:0]           i_reg;
    logic [wfm_pkg::POS_W-1:0]           nm1_reg;
    logic                                last_reg;
    logic signed [wfm_pkg::SAMPLE_W-1:0] sample_reg;
    wfm_pkg::mode_t                      mode_reg;
    logic [wfm_pkg::POS_W-1:0]           rem_reg;
    logic [16:0]                         q_reg;
    logic [2:0]                          k_reg;
    logic [18:0]                         kr_reg;
    logic [wfm_pkg::PHASE_W-1:0]         kq_reg;
    logic [wfm_pkg::COS_VAL_W-1:0]       rom_q_reg;
    logic                                neg_reg;
    logic signed [35:0]                  prod_reg;
    logic signed [wfm_pkg::ACC_W-1:0]    acc_reg;
    logic signed [wfm_pkg::WEIGHT_W-1:0] w_reg;
    logic signed [35:0]                  y_prod_reg;
    logic [wfm_pkg::OUT_W-1:0]           windowed_reg;
    logic                                frame_end_reg;

    logic [wfm_pkg::LEN_W-1:0]           n_eff;
    logic [wfm_pkg::POS_W-1:0]           nm1_in;
    logic [wfm_pkg::POS_W-1:0]           i_in;
    logic                                last_in;
    logic [16:0]                         twice;
    logic [16:0]                         tri_dist;
    logic [wfm_pkg::POS_W-1:0]           div_x;
    logic                                div_ge;
    logic [16:0]                         sh;
    logic                                sh_ge;
    logic [16:0]                         sh_sub;
    logic [19:0]                         t2;
    logic [19:0]                         m1;
    logic [19:0]                         m3;
    logic [19:0]                         m5;
    logic [19:0]                         m7;
    logic [2:0]                          rnd;
    logic [wfm_pkg::PHASE_W-1:0]         ph;
    logic [wfm_pkg::COS_IDX_W-1:0]       idx;
    logic signed [17:0]                  cos_s;
    logic signed [wfm_pkg::ACC_W-1:0]    acc_rnd;
    logic signed [wfm_pkg::ACC_W-1:0]    acc_sh;
    logic signed [wfm_pkg::WEIGHT_W-1:0] w_cos;
    logic [16:0]                         bq;
    logic [17:0]                         bw;
    logic signed [wfm_pkg::WEIGHT_W-1:0] w_next;
    logic signed [35:0]                  y_rnd;
    logic signed [35:0]                  y_sh;
    logic [wfm_pkg::OUT_W-1:0]           y_sat;
    logic                                is_rect;

    // Frame length clamp and position wrap for the incoming sample.
    always_comb
    begin
        if (frame_length < 17'd2)
            n_eff = 17'd2;
        else if (frame_length > 17'(wfm_pkg::MAX_FRAME))
            n_eff = 17'(wfm_pkg::MAX_FRAME);
        else
            n_eff = frame_length;
        nm1_in  = 16'(n_eff - 17'd1);
        i_in    = ({1'b0, position_reg} >= n_eff) ? '0 : position_reg;
        last_in = (i_in == nm1_in);
    end

    always_comb
    begin
        case (mode_reg)
            wfm_pkg::MODE_HANN, wfm_pkg::MODE_HAMMING, wfm_pkg::MODE_BLACKMAN,
            wfm_pkg::MODE_BARTLETT, wfm_pkg::MODE_BHARRIS, wfm_pkg::MODE_FLATTOP:
                is_rect = 1'b0;
            default:
                is_rect = 1'b1;
        endcase
    end

    assign status.rect      = is_rect;
    assign status.bartlett  = (mode_reg == wfm_pkg::MODE_BARTLETT);
    assign status.last_harm = (k_reg == wfm_pkg::num_harm(mode_reg));

    // Restoring divider by N-1, one quotient bit per step.
    always_comb
    begin
        twice    = {i_reg, 1'b0};
        tri_dist = (twice >= {1'b0, nm1_reg}) ? twice - {1'b0, nm1_reg}
                                               : {1'b0, nm1_reg} - twice;
        div_x    = status.bartlett ? tri_dist[15:0] : i_reg;
        div_ge   = (div_x >= nm1_reg);
        sh       = {rem_reg, 1'b0};
        sh_ge    = (sh >= {1'b0, nm1_reg});
        sh_sub   = sh - {1'b0, nm1_reg};
    end

    // Phase of harmonic k: k*Q plus the rounded share of k*R, modulo a full turn.
    always_comb
    begin
        t2  = {kr_reg, 1'b0};
        m1  = 20'(nm1_reg);
        m3  = 20'(nm1_reg) * 20'd3;
        m5  = 20'(nm1_reg) * 20'd5;
        m7  = 20'(nm1_reg) * 20'd7;
        rnd = {2'b0, t2 >= m1} + {2'b0, t2 >= m3} + {2'b0, t2 >= m5} + {2'b0, t2 >= m7};
        ph  = kq_reg + {9'b0, rnd};
        if (ph[10])
            idx = 11'(wfm_pkg::COS_DEPTH) - {1'b0, ph[9:0]};
        else
            idx = {1'b0, ph[9:0]};
        cos_s = neg_reg ? -$signed({1'b0, rom_q_reg}) : $signed({1'b0, rom_q_reg});
    end

    // Weight: rounded cosine sum, triangle, or unity.
    always_comb
    begin
        acc_rnd = acc_reg + 38'sd32768;
        acc_sh  = acc_rnd >>> 16;
        if (acc_sh > 38'(wfm_pkg::W_MAX))
            w_cos = 20'(wfm_pkg::W_MAX);
        else if (acc_sh < 38'(wfm_pkg::W_MIN))
            w_cos = 20'(wfm_pkg::W_MIN);
        else
            w_cos = acc_sh[19:0];
        bq = q_reg + {16'b0, ({rem_reg, 1'b0} >= {1'b0, nm1_reg})};
        bw = 18'(wfm_pkg::ONE_Q16) - {1'b0, bq};
        if (status.rect)
            w_next = 20'(wfm_pkg::ONE_Q16);
        else if (status.bartlett)
            w_next = $signed({2'b0, bw});
        else
            w_next = w_cos;
    end

    always_comb
    begin
        y_rnd = y_prod_reg + 36'sd32768;
        y_sh  = y_rnd >>> 16;
        if (y_sh > 36'(wfm_pkg::OUT_MAX))
            y_sat = 19'(wfm_pkg::OUT_MAX);
        else if (y_sh < 36'(wfm_pkg::OUT_MIN))
            y_sat = 19'(wfm_pkg::OUT_MIN);
        else
            y_sat = y_sh[18:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            position_reg <= '0;
            mode_reg     <= wfm_pkg::MODE_HANN;
        end
        else if (cmd.accept)
        begin
            position_reg <= last_in ? '0 : i_in + 16'd1;
            mode_reg     <= wfm_pkg::mode_t'(window_mode);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            i_reg      <= i_in;
            nm1_reg    <= nm1_in;
            last_reg   <= last_in;
            sample_reg <= $signed(sample);
        end
        if (cmd.div_load)
        begin
            rem_reg <= div_ge ? div_x - nm1_reg : div_x;
            q_reg   <= {16'b0, div_ge};
        end
        if (cmd.div_step)
        begin
            rem_reg <= sh_ge ? sh_sub[15:0] : sh[15:0];
            q_reg   <= {q_reg[15:0], sh_ge};
        end
        if (cmd.harm_init)
        begin
            k_reg   <= 3'd1;
            kr_reg  <= {3'b0, rem_reg};
            kq_reg  <= q_reg[11:0];
            acc_reg <= $signed({5'b0, wfm_pkg::base_coef(mode_reg), 16'b0});
        end
        if (cmd.harm_acc)
        begin
            k_reg   <= k_reg + 3'd1;
            kr_reg  <= kr_reg + {3'b0, rem_reg};
            kq_reg  <= kq_reg + q_reg[11:0];
            acc_reg <= acc_reg + 38'(prod_reg);
        end
        rom_q_reg <= COS_ROM[idx];
        neg_reg   <= ph[11] ^ ph[10];
        prod_reg  <= wfm_pkg::harm_coef(mode_reg, k_reg) * cos_s;
        if (cmd.weight)
            w_reg <= w_next;
        if (cmd.prod)
            y_prod_reg <= sample_reg * w_reg;
        if (cmd.out_load)
        begin
            windowed_reg  <= y_sat;
            frame_end_reg <= last_reg;
        end
    end

    assign windowed  = windowed_reg;
    assign frame_end = frame_end_reg;

endmodule

// ===== sv/wfm_ctrl.sv =====
module wfm_ctrl
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    output logic                m_tvalid,
    input  logic                m_tready,
    input  wfm_pkg::dp_status_t status,
    output wfm_pkg::dp_cmd_t    cmd
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIV_LOAD,
        ST_DIV_STEP,
        ST_HARM_INIT,
        ST_HARM_ADDR,
        ST_HARM_MUL,
        ST_HARM_ACC,
        ST_WEIGHT,
        ST_PROD,
        ST_OUTPUT
    } state_t;

    state_t     state_reg;
    state_t     state_next;
    logic [4:0] cnt_reg;
    logic [4:0] cnt_next;
    logic       m_tvalid_reg;
    logic       m_tvalid_next;

    always_comb
    begin
        cmd           = '0;
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.accept = 1'b1;
                    state_next = ST_DIV_LOAD;
                end
            end
            ST_DIV_LOAD:
            begin
                if (status.rect)
                    state_next = ST_WEIGHT;
                else
                begin
                    cmd.div_load = 1'b1;
                    cnt_next     = status.bartlett ? 5'(wfm_pkg::DIV_STEPS_LIN)
                                                   : 5'(wfm_pkg::DIV_STEPS_COS);
                    state_next   = ST_DIV_STEP;
                end
            end
            ST_DIV_STEP:
            begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg - 5'd1;
                if (cnt_reg == 5'd1)
                    state_next = status.bartlett ? ST_WEIGHT : ST_HARM_INIT;
            end
            ST_HARM_INIT:
            begin
                cmd.harm_init = 1'b1;
                state_next    = ST_HARM_ADDR;
            end
            ST_HARM_ADDR:
                state_next = ST_HARM_MUL;
            ST_HARM_MUL:
                state_next = ST_HARM_ACC;
            ST_HARM_ACC:
            begin
                cmd.harm_acc = 1'b1;
                state_next   = status.last_harm ? ST_WEIGHT : ST_HARM_ADDR;
            end
            ST_WEIGHT:
            begin
                cmd.weight = 1'b1;
                state_next = ST_PROD;
            end
            ST_PROD:
            begin
                cmd.prod   = 1'b1;
                state_next = ST_OUTPUT;
            end
            ST_OUTPUT:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    cmd.out_load  = 1'b1;
                    m_tvalid_next = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            cnt_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;

endmodule

// ===== sv/window_function_multiplier.sv =====
// Window-function multiplier: scales each sample of a frame by a window weight.
// Configure window_mode (byte address 0) and frame_length (byte address 4)
// over the APB port while no transfer is in flight; pready is always high.
// The slave stream carries one signed 16-bit sample per transfer in
// s_tdata. The master stream returns the windowed sample, rounded and
// saturated to 19 bits, in m_tdata, with m_tlast high on the last sample of
// each frame. One sample is processed at a time. The unused (unity) modes skip
// the divider; Bartlett runs the divider only; a cosine-sum window with K
// cosine terms (Hann, Hamming, Blackman, Blackman-Harris, flat top) also
// evaluates its K terms one after another. The processing time is set by the
// serial divider that forms the frame position (one quotient bit per cycle)
// and by the cosine table port, which serves one term at a time. The result
// sits in an output register; if the receiver stalls, the next sample can
// still be processed up to that register and then waits for it to drain.
// Reset clears the frame position to zero, selects Hann and a frame length
// of 1024, and empties the output register.
module window_function_multiplier
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,    // [15:0] sample
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,    // [18:0] windowed, [23:19] zero
    output logic        m_tlast
);

    // Register index, taken from the word address.
    localparam logic REG_WINDOW_MODE  = 1'b0;
    localparam logic REG_FRAME_LENGTH = 1'b1;

    logic [2:0]                      window_mode_reg;
    logic [wfm_pkg::LEN_W-1:0]       frame_length_reg;
    logic                            cfg_write;
    wfm_pkg::dp_cmd_t                cmd;
    wfm_pkg::dp_status_t             status;
    logic [wfm_pkg::OUT_W-1:0]       windowed;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_mode_reg  <= wfm_pkg::MODE_HANN;
            frame_length_reg <= 17'd1024;
        end
        else if (cfg_write)
        begin
            unique case (paddr[2])
                REG_WINDOW_MODE:  window_mode_reg  <= pwdata[2:0];
                REG_FRAME_LENGTH: frame_length_reg <= pwdata[16:0];
                default:          window_mode_reg  <= window_mode_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            REG_WINDOW_MODE:  prdata = {29'b0, window_mode_reg};
            REG_FRAME_LENGTH: prdata = {15'b0, frame_length_reg};
            default:          prdata = '0;
        endcase
    end

    wfm_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    wfm_dp u_dp
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .window_mode  (window_mode_reg),
        .frame_length (frame_length_reg),
        .sample       (s_tdata),
        .windowed     (windowed),
        .frame_end    (m_tlast)
    );

    assign m_tdata = {5'b0, windowed};

    // Only one sample is in the datapath at a time.
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input accepted while a sample is in progress");

    // A new result is published only from the output state, never while idle.
    a_result_after_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(!s_tready))
        else $error("result appeared without processing a sample");

    // The triangle and unity weight paths are exclusive.
    a_weight_path: assert property (@(posedge clk) disable iff (!rst_n)
        !(status.rect && status.bartlett))
        else $error("conflicting weight path selection");

endmodule

// ===== sim/window_function_multiplier_tb.sv =====
`timescale 1ns / 1ps

module window_function_multiplier_tb;

    localparam int REG_MODE   = 0;
    localparam int REG_LENGTH = 1;
    localparam int WATCHDOG   = 20000;

    typedef struct {
        logic signed [18:0] windowed;
        logic               frame_end;
    } windowed_t;

    // Directed rows: configuration, sample, and for the obvious cases the
    // expected output typed in.
    typedef struct {
        int          mode;
        int          length;
        logic [15:0] sample;
        bit          check;
        int          windowed;
        bit          frame_end;
    } direct_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;
    logic        m_tlast;

    // Predictor state: mirrors the block's registers and frame position.
    logic [2:0]        cur_mode;
    logic [16:0]       cur_length;
    int                frame_pos;
    wfm_pkg::cos_rom_t cos_tab;

    windowed_t   expected_q[$];
    direct_row_t directed[$];
    int          errors = 0;
    int          results_seen = 0;
    int          idle_cycles = 0;
    bit          no_idle = 1'b0;
    bit          hold_sink = 1'b0;

    window_function_multiplier u_top
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),    // [15:0] sample
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),    // [18:0] windowed, [23:19] zero
        .m_tlast  (m_tlast)
    );

    always #2 clk = ~clk;

    // Builds the quarter-wave cosine table in Q16 with the same Q30 series the
    // block specifies, so the predictor matches it bit for bit.
    function automatic void make_cos_table();
        longint unsigned x, x2, term;
        longint          acc, e;
        for (int j = 0; j <= wfm_pkg::COS_DEPTH; j++)
        begin
            x    = (64'd1686629713 * 64'(j) + 64'd512) / 64'd1024;
            x2   = (x * x) >> 30;
            term = 64'd1 << 30;
            acc  = longint'(term);
            for (int n = 1; n <= 12; n++)
            begin
                term = ((term * x2) >> 30) / 64'((2 * n - 1) * (2 * n));
                acc  = (n % 2 == 1) ? acc - longint'(term) : acc + longint'(term);
            end
            if (acc < 0)
                acc = 0;
            e = (acc + 8192) / 16384;
            if (e > 65536)
                e = 65536;
            cos_tab[j] = 17'(e);
        end
    endfunction

    // Floor of (v + 2^15) / 2^16, done without relying on shift semantics.
    function automatic longint round_half_up_q16(longint v);
        longint t;
        t = v + 32768;
        if (t >= 0)
            return t / 65536;
        return -((-t + 65535) / 65536);
    endfunction

    // cos(2*pi*k*i/(N-1)) in Q16 from the quarter-wave table.
    function automatic longint harmonic_cos(int k, longint i, longint nm1);
        longint ph, q, r;
        ph = ((2 * 4096 * k * i + nm1) / (2 * nm1)) % 4096;
        q  = ph / 1024;
        r  = ph % 1024;
        case (q)
            0: return longint'(cos_tab[r]);
            1: return -longint'(cos_tab[1024 - r]);
            2: return -longint'(cos_tab[r]);
            default: return longint'(cos_tab[1024 - r]);
        endcase
    endfunction

    function automatic longint window_weight(longint i, longint n);
        longint nm1, a, acc, w, c1, c2, c3, c4;
        nm1 = n - 1;
        if (cur_mode == wfm_pkg::MODE_BARTLETT)
        begin
            a = (2 * i >= nm1) ? 2 * i - nm1 : nm1 - 2 * i;
            return 65536 - (a * 131072 + nm1) / (2 * nm1);
        end
        if (cur_mode > wfm_pkg::MODE_FLATTOP)
            return wfm_pkg::ONE_Q16;
        c1 = harmonic_cos(1, i, nm1);
        c2 = harmonic_cos(2, i, nm1);
        c3 = harmonic_cos(3, i, nm1);
        c4 = harmonic_cos(4, i, nm1);
        case (cur_mode)
            wfm_pkg::MODE_HANN:     acc = 32768 * 65536 - 32768 * c1;
            wfm_pkg::MODE_HAMMING:  acc = 35389 * 65536 - 30147 * c1;
            wfm_pkg::MODE_BLACKMAN: acc = 27525 * 65536 - 32768 * c1 + 5243 * c2;
            wfm_pkg::MODE_BHARRIS:
                acc = 23511 * 65536 - 32001 * c1 + 9259 * c2 - 765 * c3;
            default:
                acc = 65536 * 65536 - 126484 * c1 + 84541 * c2 - 25428 * c3 + 2110 * c4;
        endcase
        w = round_half_up_q16(acc);
        if (w > wfm_pkg::W_MAX) w = wfm_pkg::W_MAX;
        if (w < wfm_pkg::W_MIN) w = wfm_pkg::W_MIN;
        return w;
    endfunction

    // Works out the windowed sample for one accepted transfer and advances
    // the frame position.
    function automatic windowed_t window_sample(logic [15:0] raw);
        windowed_t r;
        longint    n, w, y;
        n = cur_length;
        if (n < 2) n = 2;
        if (n > wfm_pkg::MAX_FRAME) n = wfm_pkg::MAX_FRAME;
        if (frame_pos >= n) frame_pos = 0;
        w = window_weight(frame_pos, n);
        y = round_half_up_q16(longint'($signed(raw)) * w);
        if (y > wfm_pkg::OUT_MAX) y = wfm_pkg::OUT_MAX;
        if (y < wfm_pkg::OUT_MIN) y = wfm_pkg::OUT_MIN;
        r.windowed  = 19'(y);
        r.frame_end = (frame_pos == n - 1);
        frame_pos   = r.frame_end ? 0 : frame_pos + 1;
        return r;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("MISMATCH at result %0d: %s got %0d expected %0d",
                 results_seen, what, got, want);
        errors++;
    endtask

    // One register write; the bus is left idle afterwards.
    task automatic apb_write(int index, logic [31:0] value);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        paddr   <= 3'(4 * index);
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (index == REG_MODE)
            cur_mode = value[2:0];
        else
            cur_length = value[16:0];
        @(posedge clk);
    endtask

    // Stops offering, waits for all results, then lets the block settle.
    task automatic drain();
        s_tvalid <= 1'b0;
        while (expected_q.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    // Offers one sample and holds it until the transfer completes. Valid stays
    // high afterwards; the next call or drain decides what follows.
    task automatic send_sample(logic [15:0] value);
        if (!no_idle && $urandom_range(0, 3) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= value;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        expected_q.push_back(window_sample(value));
    endtask

    task automatic add_row(int mode, int length, logic [15:0] sample, bit check,
                           int windowed, bit frame_end);
        direct_row_t row;
        row.mode      = mode;
        row.length    = length;
        row.sample    = sample;
        row.check     = check;
        row.windowed  = windowed;
        row.frame_end = frame_end;
        directed.push_back(row);
    endtask

    // Receiver: random stall bursts, or a long hold-off when requested.
    initial
    begin
        int gap;
        forever
        begin
            @(posedge clk);
            if (!rst_n || hold_sink)
                m_tready <= 1'b0;
            else if (!no_idle && $urandom_range(0, 5) == 0)
            begin
                m_tready <= 1'b0;
                gap = $urandom_range(1, 4);
                repeat (gap - 1) @(posedge clk);
            end
            else
                m_tready <= 1'b1;
        end
    end

    // Checks each accepted result against the oldest expectation.
    always @(posedge clk)
    begin
        windowed_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_q.size() == 0)
                report_mismatch("unexpected result", m_tdata, 0);
            else
            begin
                want = expected_q.pop_front();
                if (m_tdata[18:0] !== want.windowed)
                    report_mismatch("windowed", $signed(m_tdata[18:0]), want.windowed);
                if (m_tdata[23:19] !== '0)
                    report_mismatch("pad bits", m_tdata[23:19], 0);
                if (m_tlast !== want.frame_end)
                    report_mismatch("frame_end", m_tlast, want.frame_end);
            end
            results_seen++;
        end
    end

    // Watchdog: counts cycles with no transfer on either stream and no APB access.
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || psel)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG)
        begin
            $display("watchdog expired with %0d results outstanding", expected_q.size());
            $display("window_function_multiplier test failed");
            $finish;
        end
    end

    task automatic random_phase(int count);
        logic [15:0] v;
        for (int k = 0; k < count; k++)
        begin
            case ($urandom_range(0, 5))
                0: v = 16'h8000;
                1: v = 16'h7fff;
                default: v = 16'($urandom());
            endcase
            send_sample(v);
        end
    endtask

    initial
    begin
        windowed_t typed;
        int        len;
        bit        known;
        make_cos_table();
        cur_mode   = wfm_pkg::MODE_HANN;
        cur_length = 17'd1024;
        frame_pos  = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Unity mode with a two-sample frame: output equals the sample.
        add_row(6, 2, 16'h7fff, 1, 32767, 0);
        add_row(6, 2, 16'h8000, 1, -32768, 1);
        add_row(6, 2, 16'h0000, 1, 0, 0);
        add_row(6, 2, 16'hffff, 1, -1, 1);

        // Every window at the frame edges and center, with extreme samples.
        // Hann and Bartlett are zero at the edges and unity at the center.
        for (int m = 0; m < 8; m++)
        begin
            known = (m == 0) || (m == 3);
            if (m >= 6)
            begin
                add_row(m, 3, 16'h7fff, 1, 32767, 0);
                add_row(m, 3, 16'h8000, 1, -32768, 0);
                add_row(m, 3, 16'h7fff, 1, 32767, 1);
            end
            else
            begin
                add_row(m, 3, 16'h7fff, known, 0, 0);
                add_row(m, 3, 16'h8000, known, -32768, 0);
                add_row(m, 3, 16'h7fff, known, 0, 1);
            end
        end

        // A frame length below two acts as two.
        add_row(7, 0, 16'h1234, 1, 4660, 0);
        add_row(7, 0, 16'h8000, 1, -32768, 1);

        // Frame shortened mid-frame: the position restarts at zero.
        for (int r = 0; r < 7; r++)
            add_row(7, 10, 16'h7fff, 1, 32767, 0);
        add_row(7, 4, 16'h4000, 1, 16384, 0);

        foreach (directed[r])
        begin
            if (directed[r].mode != int'(cur_mode) || directed[r].length != int'(cur_length))
            begin
                drain();
                if (directed[r].mode != int'(cur_mode))
                    apb_write(REG_MODE, directed[r].mode);
                if (directed[r].length != int'(cur_length))
                    apb_write(REG_LENGTH, directed[r].length);
            end
            send_sample(directed[r].sample);
            if (directed[r].check)
            begin
                typed.windowed  = 19'(directed[r].windowed);
                typed.frame_end = directed[r].frame_end;
                expected_q[expected_q.size() - 1] = typed;
            end
        end
        drain();

        // Receiver holds off while the sender keeps offering.
        hold_sink = 1'b1;
        fork
            random_phase(6);
            begin
                repeat (300) @(posedge clk);
                hold_sink = 1'b0;
            end
        join
        drain();

        // Random phases across modes and lengths, including the extremes.
        for (int ph = 0; ph < 24; ph++)
        begin
            apb_write(REG_MODE, $urandom_range(0, 7));
            case (ph % 6)
                0: len = 65536;
                1: len = 2;
                2: len = 131071;
                default: len = $urandom_range(2, 80);
            endcase
            apb_write(REG_LENGTH, len);
            if (ph >= 20)
                no_idle = 1'b1;
            random_phase(58);
            drain();
        end

        $display("Covered all eight window modes, frame lengths from 0 to 131071,");
        $display("%0d results checked with stalls, a long hold-off and mid-frame length change.",
                 results_seen);
        if (errors == 0)
            $display("window_function_multiplier test passed");
        else
            $display("window_function_multiplier test failed");
        $finish;
    end

endmodule
